// File: design/assert_macros.svh
// Assertion macros used by the at_rfp engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define AST_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define AST_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define AST_CLK(lbl, clk, rstn, prop, msg)
`define AST_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// File: design/at_rfp_pkg.sv
// Types and constants for the AT response frame parser.
package at_rfp_pkg;
	localparam int BUF_SIZE = 256;
	localparam int FILL_W   = $clog2(BUF_SIZE + 1);
	localparam int INDEX_W  = 8;
	localparam int LEN_W    = 9;
	localparam int HDR_LEN  = 6;
	localparam int SHORT_LEN = 2;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_PLUS = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_DIGITS = 2'd1,
		PH_DONE   = 2'd3
	} phase_t;

	typedef struct packed {
		logic               store_valid;
		logic               buffer_select;
		logic [INDEX_W-1:0] write_index;
		logic [7:0]         store_data;
		logic               message_done;
		logic [LEN_W-1:0]   message_length;
		logic               overflow;
	} res_t;

	// "+RECV:" header characters by position
	function automatic logic [7:0] hdr_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0: ch = 8'h2B;
			3'd1: ch = 8'h52;
			3'd2: ch = 8'h45;
			3'd3: ch = 8'h43;
			3'd4: ch = 8'h56;
			3'd5: ch = 8'h3A;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction
endpackage

// File: design/at_rfp_engine.sv
// Line/payload framing state and per-byte result logic.
`include "assert_macros.svh"
module at_rfp_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [7:0]        rx_byte,
	output at_rfp_pkg::res_t  res
);
	import at_rfp_pkg::*;

	logic [FILL_W-1:0] fill_q, fill_n;
	logic [7:0]        prev_q, prev_n;
	logic              prefix_q, prefix_n;
	phase_t            phase_q, phase_n;
	logic              neg_q, neg_n;
	logic [7:0]        acc_q, acc_n;
	logic [7:0]        pay_q, pay_n;
	logic              active_q, active_n;

	logic              full;
	logic              done;
	logic              restart;
	logic              crlf;
	logic              is_digit;
	logic [7:0]        digit;
	logic [FILL_W-1:0] fill_inc;

	always_comb begin
		full     = fill_q >= FILL_W'(BUF_SIZE);
		fill_inc = fill_q + FILL_W'(1);
		is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
		digit    = rx_byte - CHAR_ZERO;
		crlf     = (fill_q != '0) && (prev_q == CHAR_CR) && (rx_byte == CHAR_LF);

		fill_n   = fill_q;
		prev_n   = prev_q;
		prefix_n = prefix_q;
		phase_n  = phase_q;
		neg_n    = neg_q;
		acc_n    = acc_q;
		pay_n    = pay_q;
		active_n = active_q;
		done     = 1'b0;
		restart  = 1'b0;

		res                = '0;
		res.buffer_select  = active_q;

		if (full) begin
			restart      = 1'b1;
			res.overflow = 1'b1;
		end else begin
			fill_n = fill_inc;
			prev_n = rx_byte;
			if (pay_q != 8'd0) begin
				pay_n = pay_q - 8'd1;
				done  = (pay_q == 8'd1);
			end else begin
				if (fill_q < FILL_W'(HDR_LEN)) begin
					if (rx_byte != hdr_char(fill_q[2:0]))
						prefix_n = 1'b0;
				end else if (prefix_q) begin
					// atoi-style count after the header, mod 256
					case (phase_q)
						PH_SKIP: begin
							if (rx_byte inside {8'h20, [8'h09:8'h0D]}) begin
								phase_n = PH_SKIP;
							end else if (rx_byte == CHAR_PLUS || rx_byte == CHAR_MINUS) begin
								neg_n   = (rx_byte == CHAR_MINUS);
								phase_n = PH_DIGITS;
							end else if (is_digit) begin
								acc_n   = digit;
								phase_n = PH_DIGITS;
							end else begin
								phase_n = PH_DONE;
							end
						end
						PH_DIGITS: begin
							if (is_digit)
								acc_n = (acc_q << 3) + (acc_q << 1) + digit;
							else
								phase_n = PH_DONE;
						end
						default: phase_n = phase_q;
					endcase
				end

				if (crlf) begin
					if (fill_q >= FILL_W'(HDR_LEN) && prefix_q)
						pay_n = neg_q ? (8'd0 - acc_q) : acc_q;
					else if (fill_q >= FILL_W'(SHORT_LEN))
						done = 1'b1;
					else
						restart = 1'b1;
				end
			end

			res.store_valid = 1'b1;
			res.write_index = fill_q[INDEX_W-1:0];
			res.store_data  = rx_byte;
			res.message_done = done;
			if (done)
				res.message_length = LEN_W'(fill_inc);
		end

		if (done) begin
			active_n = ~active_q;
			restart  = 1'b1;
		end

		if (restart) begin
			fill_n   = '0;
			prefix_n = 1'b1;
			phase_n  = PH_SKIP;
			neg_n    = 1'b0;
			acc_n    = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			prev_q   <= 8'd0;
			prefix_q <= 1'b1;
			phase_q  <= PH_SKIP;
			neg_q    <= 1'b0;
			acc_q    <= 8'd0;
			pay_q    <= 8'd0;
			active_q <= 1'b0;
		end else if (en) begin
			fill_q   <= fill_n;
			prev_q   <= prev_n;
			prefix_q <= prefix_n;
			phase_q  <= phase_n;
			neg_q    <= neg_n;
			acc_q    <= acc_n;
			pay_q    <= pay_n;
			active_q <= active_n;
		end
	end

	`AST_CLK(a_done_swaps, clk, arst_n, en && res.message_done |=> active_q != $past(active_q), "buffer not swapped after message")
	`AST_CLK(a_ovf_clears, clk, arst_n, en && res.overflow |=> fill_q == '0, "fill not cleared on overflow")
	`AST_NEVER(a_fill_range, clk, arst_n, fill_q > FILL_W'(BUF_SIZE), "fill count beyond buffer size")
	`AST_CLK(a_pay_dec, clk, arst_n, en && !res.overflow && pay_q != 8'd0 |=> pay_q == $past(pay_q) - 8'd1, "payload count not decremented")
endmodule

// File: design/at_response_frame_parser_top.sv
// Byte stream in, buffer write/complete transactions out.
//
// s_* channel: one received UART byte per transaction (s_tdata[7:0]).
// m_* channel: one result per input byte: the buffer write of that byte,
// or an overflow report when the active buffer was already full.
// m_tlast marks a byte that completes a message; m_tuser names the
// ping-pong buffer that is written or completed.
// A byte accepted into the input register passes through the framing logic
// into the result register, which presents it on m_*.
// Throughput: one byte per cycle while m_tready is high; the input
// register and the result register each hold one transaction, and the
// framing state updates as a byte moves from the input register to the result.
// When m_tready is low the result holds, the input register fills, and
// s_tready then drops until the result is taken.
// Reset (arst_n low) empties both registers, clears fill count and payload
// count, restarts header/count parsing and selects buffer 0.
module at_response_frame_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [0] store_valid, [8:1] write_index, [16:9] store_data,
	                               // [25:17] message_length, [26] overflow, [31:27] zero
	output logic        m_tlast,   // message_done
	output logic        m_tuser    // buffer_select
);
	import at_rfp_pkg::*;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       vld_s2;
	res_t       res_s2;
	res_t       res;
	logic       advance;

	assign advance  = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || advance;

	at_rfp_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.rx_byte (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				vld_s1 <= 1'b1;
			else if (advance)
				vld_s1 <= 1'b0;
			if (advance)
				vld_s2 <= 1'b1;
			else if (m_tready)
				vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			byte_s1 <= s_tdata;
		if (advance)
			res_s2 <= res;
	end

	assign m_tvalid = vld_s2;
	assign m_tlast  = res_s2.message_done;
	assign m_tuser  = res_s2.buffer_select;
	assign m_tdata  = {5'd0, res_s2.overflow, res_s2.message_length, res_s2.store_data,
		res_s2.write_index, res_s2.store_valid};
endmodule
